/* rtl/distance_square_dilation_macros.svh */
//----------------------------------------------------------------------------
// Assertion macros for the square dilation block
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
//----------------------------------------------------------------------------
`ifndef DISTANCE_SQUARE_DILATION_MACROS_SVH
`define DISTANCE_SQUARE_DILATION_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DSD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: condition must never hold");

`define DSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`define DSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`else

`define DSD_ASSERT_NEVER(label, clk, rst, expr)
`define DSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define DSD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/dsd_pkg.sv */
//----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the square dilation block.
//----------------------------------------------------------------------------
package dsd_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int COORD_W   = 10;   // frame registers and clipped coordinates
   localparam int POS_W     = 9;
   localparam int CODE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int LEVEL_W   = 8;
   localparam int CLAMP_W   = 13;   // holds the largest MAX_WIDTH or MAX_HEIGHT
   localparam int RADIUS_W  = 5;
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;    // bit offset inside a mark word
   localparam int WSEL_W    = COORD_W - BIT_W;
   localparam int QUEUE_DEPTH = 2;

   // Division of the distance code by 10: (code * 205) >> 11 is exact for
   // every 8-bit code.
   localparam int RECIP_MUL   = 205;
   localparam int RECIP_SHIFT = 11;
   localparam int PROD_W      = 16;

   localparam logic [COORD_W-1:0] FRAME_RESET = 10'd512;
   localparam logic [LEVEL_W-1:0] LEVEL_ON    = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_OFF   = 8'd0;

   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAINT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_PAINT = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // A classified command. For a read only x0 and y0 matter.
   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
   } cmd_type;

endpackage

/* rtl/dsd_cmd_queue.sv */
//----------------------------------------------------------------------------
// dsd_cmd_queue
// Short first-in first-out queue of classified commands between the front
// and the back.
//----------------------------------------------------------------------------
module dsd_cmd_queue import dsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/dsd_front.sv */
//----------------------------------------------------------------------------
// dsd_front
// Holds the frame registers, accepts requests and turns each one into a
// clipped command for the back.
//----------------------------------------------------------------------------
module dsd_front import dsd_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // pos_x, pos_y, source_level, zero fill
   input  logic [KIND_W-1:0]  req_tuser,   // kind
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [COORD_W-1:0] csr_data,
   input  logic               init_busy,
   input  logic               q_ready,
   output logic               q_push,
   output cmd_type            q_cmd
);

   typedef struct packed {
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
   } span_type;

   logic [COORD_W-1:0] frame_width_ff, frame_width_in;
   logic [COORD_W-1:0] frame_height_ff, frame_height_in;

   logic [POS_W-1:0]    pos_x, pos_y;
   logic [CODE_W-1:0]   source_level;
   logic [COORD_W-1:0]  eff_w, eff_h;
   logic [PROD_W-1:0]   prod;
   logic [RADIUS_W-1:0] quot, radius;
   logic                in_frame;
   span_type            span_x, span_y;

   // Clips the span c-g .. c+g to 0 .. last.
   function automatic span_type clip_span(input logic [COORD_W-1:0] c,
                                          input logic [RADIUS_W-1:0] g,
                                          input logic [COORD_W-1:0] last);
      span_type           s;
      logic [COORD_W-1:0] g_ext;
      logic [COORD_W-1:0] top;
      g_ext = COORD_W'(g);
      top   = c + g_ext;
      s.lo  = (c >= g_ext) ? c - g_ext : '0;
      s.hi  = (top > last) ? last : top;
      return s;
   endfunction

   assign pos_x        = req_tdata[8:0];
   assign pos_y        = req_tdata[17:9];
   assign source_level = req_tdata[25:18];

   assign req_tready = q_ready && !init_busy;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_data;
            REG_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_RESET;
         frame_height_ff <= FRAME_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      eff_w = (CLAMP_W'(frame_width_ff) > CLAMP_W'(MAX_WIDTH)) ?
              COORD_W'(MAX_WIDTH) : frame_width_ff;
      eff_h = (CLAMP_W'(frame_height_ff) > CLAMP_W'(MAX_HEIGHT)) ?
              COORD_W'(MAX_HEIGHT) : frame_height_ff;
      prod     = PROD_W'(source_level) * PROD_W'(RECIP_MUL);
      quot     = RADIUS_W'(prod >> RECIP_SHIFT);
      radius   = quot - 1'b1;
      in_frame = (COORD_W'(pos_x) < eff_w) && (COORD_W'(pos_y) < eff_h);
      span_x   = clip_span(COORD_W'(pos_x), radius, eff_w - 1'b1);
      span_y   = clip_span(COORD_W'(pos_y), radius, eff_h - 1'b1);

      q_cmd.op = OP_NOP;
      q_cmd.x0 = COORD_W'(pos_x);
      q_cmd.x1 = COORD_W'(pos_x);
      q_cmd.y0 = COORD_W'(pos_y);
      q_cmd.y1 = COORD_W'(pos_y);
      case (req_tuser)
         KIND_CLEAR: q_cmd.op = OP_CLEAR;
         KIND_PAINT: begin
            if (in_frame && quot != '0) begin
               q_cmd.op = OP_PAINT;
               q_cmd.x0 = span_x.lo;
               q_cmd.x1 = span_x.hi;
               q_cmd.y0 = span_y.lo;
               q_cmd.y1 = span_y.hi;
            end
         end
         KIND_READ: begin
            if (in_frame) begin
               q_cmd.op = OP_READ;
            end
         end
         default: q_cmd.op = OP_NOP;
      endcase
   end

endmodule

/* rtl/dsd_back.sv */
//----------------------------------------------------------------------------
// dsd_back
// Owns the mark memory, executes clear, paint and read commands word by
// word and holds the result register.
//----------------------------------------------------------------------------
`include "distance_square_dilation_macros.svh"

module dsd_back import dsd_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   output logic               init_busy,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [LEVEL_W-1:0] rsp_tdata    // level
);

   localparam int WORDS_PER_ROW = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int MEM_DEPTH     = MAX_HEIGHT * WORDS_PER_ROW;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_PRD   = 3'd3;
   localparam logic [2:0] S_PWR   = 3'd4;
   localparam logic [2:0] S_RRD   = 3'd5;
   localparam logic [2:0] S_RWT   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [WORD_BITS-1:0] mem [MEM_DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [2:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic [WSEL_W-1:0]    word_ff, word_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic                 sweeping, sweep_last, out_free;
   logic [ADDR_W-1:0]    word_addr, mem_addr;
   logic                 mem_we, mem_re;
   logic [WORD_BITS-1:0] mem_wdata, mask;
   logic [BIT_W-1:0]     bit_lo, bit_hi;
   logic [WSEL_W-1:0]    word_last;

   assign sweeping   = (state_ff == S_INIT) || (state_ff == S_CLEAR);
   assign sweep_last = (sweep_ff == ADDR_W'(MEM_DEPTH - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign word_last  = cmd_ff.x1[COORD_W-1:BIT_W];
   assign word_addr  = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(word_ff));
   assign mem_addr   = sweeping ? sweep_ff : word_addr;
   assign init_busy  = (state_ff == S_INIT);
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;

   // Bit range of the current word that lies inside the painted span.
   always_comb begin
      bit_lo = (word_ff == cmd_ff.x0[COORD_W-1:BIT_W]) ? cmd_ff.x0[BIT_W-1:0] : '0;
      bit_hi = (word_ff == word_last) ? cmd_ff.x1[BIT_W-1:0] : '1;
      mask   = ({WORD_BITS{1'b1}} << bit_lo) & ({WORD_BITS{1'b1}} >> (~bit_hi));
   end

   assign mem_we    = sweeping || (state_ff == S_PWR);
   assign mem_re    = (state_ff == S_PRD) || (state_ff == S_RRD);
   assign mem_wdata = sweeping ? '0 : (rdata_ff | mask);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      row_in       = row_ff;
      word_in      = word_ff;
      sweep_in     = sweep_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      case (state_ff)
         S_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               row_in   = q_cmd.y0;
               word_in  = q_cmd.x0[COORD_W-1:BIT_W];
               sweep_in = '0;
               level_in = LEVEL_OFF;
               case (q_cmd.op)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_PAINT: state_in = S_PRD;
                  OP_READ:  state_in = S_RRD;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_PRD: state_in = S_PWR;
         S_PWR: begin
            if (word_ff != word_last) begin
               word_in  = word_ff + 1'b1;
               state_in = S_PRD;
            end else if (row_ff != cmd_ff.y1) begin
               row_in   = row_ff + 1'b1;
               word_in  = cmd_ff.x0[COORD_W-1:BIT_W];
               state_in = S_PRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RRD: state_in = S_RWT;
         S_RWT: begin
            level_in = rdata_ff[cmd_ff.x0[BIT_W-1:0]] ? LEVEL_ON : LEVEL_OFF;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      row_ff       <= row_in;
      word_ff      <= word_in;
      level_ff     <= level_in;
      rsp_level_ff <= rsp_level_in;
   end

   `DSD_ASSERT_NEVER(a_no_read_on_write, clock, reset, mem_we && mem_re)
   `DSD_ASSERT_NEXT(a_write_follows_read, clock, reset, state_ff == S_PRD, state_ff == S_PWR)
   `DSD_ASSERT_IMPLIES(a_paint_in_span, clock, reset, state_ff == S_PWR, (row_ff <= cmd_ff.y1) && (word_ff <= word_last))

endmodule

/* rtl/distance_square_dilation.sv */
// Read: the mark word is read (S_RRD), its bit is sampled (S_RWT) and the level is offered (S_DONE).
// Paint: a read-modify-write per 64-bit mark word (S_PRD, S_PWR), one or two words per row over
// up to 49 rows. Clear: one memory word a cycle, over 4096 words by default.
// One request runs in the back at a time; two more can wait in the command queue.
// Reset is synchronous; afterwards a clearing pass over MAX_HEIGHT * ceil(MAX_WIDTH / 64)
// mark words runs with req_tready low. Frame registers reset to 512.
//----------------------------------------------------------------------------
// distance_square_dilation
// Square dilation of a distance-coded image into a one-bit mark memory.
//----------------------------------------------------------------------------
module distance_square_dilation import dsd_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // pos_x [8:0], pos_y [17:9], source_level [25:18]
   input  logic [KIND_W-1:0]  req_tuser,   // kind
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [LEVEL_W-1:0] rsp_tdata,   // level
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [COORD_W-1:0] csr_data
);

   logic    init_busy;
   logic    q_ready, q_push, q_valid, q_pop;
   cmd_type push_cmd, pop_cmd;

   dsd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .init_busy  (init_busy),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   dsd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (pop_cmd),
      .pop        (q_pop)
   );

   dsd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/tb_distance_square_dilation.sv */
//----------------------------------------------------------------------------
// tb_distance_square_dilation
// Drives clear, paint and read requests into the square dilation block and
// checks every response against a typed level or the bench's bit-level mark
// map. A short table of directed requests covers corners, clipping, tiny and
// oversized frames and the unused kind. Random phases follow, each under its
// own frame size. Most random reads land on recently painted squares.
//----------------------------------------------------------------------------
module tb_distance_square_dilation;
   import dsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE            = DEF_MAX_WIDTH;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int PHASES          = 6;
   localparam int QUIET_LIMIT     = 60000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_FRAME} row_act_type;

   // For a frame row, a and b are the new width and height.
   typedef struct packed {
      row_act_type        act;
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
      logic [CODE_W-1:0]  code;
      logic               typed;
      logic [LEVEL_W-1:0] want;
   } plan_row_type;

   localparam int PLAN_ROWS = 29;
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_ITEM,  KIND_READ,   10'd0,    10'd0,    8'd0,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd0,    10'd0,    8'd255, 1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd24,   10'd24,   8'd0,   1'b1, LEVEL_ON},
      '{ROW_ITEM,  KIND_READ,   10'd25,   10'd0,    8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd511,  10'd511,  8'd10,  1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd511,  10'd511,  8'd0,   1'b1, LEVEL_ON},
      '{ROW_ITEM,  KIND_PAINT,  10'd100,  10'd100,  8'd9,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd100,  10'd100,  8'd0,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_UNUSED, 10'd511,  10'd511,  8'd255, 1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd300,  10'd200,  8'd0,   1'b0, LEVEL_OFF},
      '{ROW_FRAME, KIND_CLEAR,  10'd1023, 10'd1023, 8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd505,  10'd300,  8'd255, 1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd511,  10'd300,  8'd0,   1'b0, LEVEL_OFF},
      '{ROW_FRAME, KIND_CLEAR,  10'd0,    10'd1023, 8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd10,   10'd10,   8'd255, 1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd24,   10'd24,   8'd0,   1'b1, LEVEL_OFF},
      '{ROW_FRAME, KIND_CLEAR,  10'd40,   10'd30,   8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd45,   10'd10,   8'd200, 1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd50,   10'd10,   8'd0,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd39,   10'd29,   8'd30,  1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd37,   10'd27,   8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd24,   10'd24,   8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_CLEAR,  10'd0,    10'd0,    8'd0,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd24,   10'd24,   8'd0,   1'b1, LEVEL_OFF},
      '{ROW_FRAME, KIND_CLEAR,  10'd512,  10'd512,  8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd511,  10'd300,  8'd0,   1'b1, LEVEL_OFF},
      '{ROW_ITEM,  KIND_PAINT,  10'd256,  10'd256,  8'd170, 1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd240,  10'd272,  8'd0,   1'b0, LEVEL_OFF},
      '{ROW_ITEM,  KIND_READ,   10'd239,  10'd256,  8'd0,   1'b0, LEVEL_OFF}
   };

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [31:0]        req_tdata;   // pos_x [8:0], pos_y [17:9], source_level [25:18]
   logic [KIND_W-1:0]  req_tuser;   // kind
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [LEVEL_W-1:0] rsp_tdata;   // level
   logic               csr_wr_en;
   logic               csr_index;
   logic [COORD_W-1:0] csr_data;

   // Bench copy of the mark memory and the frame registers.
   logic [SIDE-1:0]    mark_rows [SIDE];
   logic [COORD_W-1:0] frame_w;
   logic [COORD_W-1:0] frame_h;

   logic [LEVEL_W-1:0] pending_levels [$];
   int                 mismatches;
   int                 burst_left;
   int                 quiet_cycles;
   int                 hot_x;
   int                 hot_y;
   int                 hot_r;
   int                 stall_mode;
   int                 stall_left;
   int                 stall_phase;

   distance_square_dilation u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int visible_width();
      return (frame_w > SIDE) ? SIDE : int'(frame_w);
   endfunction

   function automatic int visible_height();
      return (frame_h > SIDE) ? SIDE : int'(frame_h);
   endfunction

   // Applies one request to the mark map and returns the level it answers.
   function automatic logic [LEVEL_W-1:0] dilate_and_sample(
      input logic [KIND_W-1:0] k,
      input logic [POS_W-1:0]  x,
      input logic [POS_W-1:0]  y,
      input logic [CODE_W-1:0] code
   );
      int                 w;
      int                 h;
      int                 rad;
      int                 px;
      int                 py;
      logic [LEVEL_W-1:0] lvl;
      w   = visible_width();
      h   = visible_height();
      lvl = LEVEL_OFF;
      case (k)
         KIND_CLEAR: begin
            for (py = 0; py < SIDE; py++)
               mark_rows[py] = '0;
         end
         KIND_PAINT: begin
            rad = int'(code) / 10 - 1;
            if (x < w && y < h && rad >= 0) begin
               for (py = int'(y) - rad; py <= int'(y) + rad; py++) begin
                  if (py < 0 || py >= h)
                     continue;
                  for (px = int'(x) - rad; px <= int'(x) + rad; px++) begin
                     if (px >= 0 && px < w)
                        mark_rows[py][px] = 1'b1;
                  end
               end
            end
         end
         KIND_READ: begin
            if (x < w && y < h && mark_rows[y][x])
               lvl = LEVEL_ON;
         end
         default: lvl = LEVEL_OFF;
      endcase
      return lvl;
   endfunction

   // Lowers tvalid; call only in a step where it is not also raised.
   // With no burst running, tvalid is already low.
   task automatic hold_requests();
      if (burst_left != 0)
         req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic drain_responses();
      hold_requests();
      while (pending_levels.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_frame(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
      drain_responses();
      // The bench idles between the last response and the register writes.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_w = w;
      frame_h = h;
   endtask

   task automatic send_request(
      input logic [KIND_W-1:0] k,
      input logic [POS_W-1:0]  x,
      input logic [POS_W-1:0]  y,
      input logic [CODE_W-1:0] code,
      input logic              typed,
      input logic [LEVEL_W-1:0] want
   );
      int                 gap;
      logic [LEVEL_W-1:0] lvl;
      if (burst_left == 0) begin
         case ($urandom_range(0, 19))
            0:       gap = $urandom_range(21, 60);
            1, 2, 3,
            4, 5:    gap = $urandom_range(4, 20);
            default: gap = $urandom_range(1, 3);
         endcase
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {6'd0, code, y, x};
      do
         @(posedge clock);
      while (!req_tready);
      lvl = dilate_and_sample(k, x, y, code);
      pending_levels.push_back(typed ? want : lvl);
      burst_left--;
      if (burst_left == 0)
         req_tvalid <= 1'b0;
   endtask

   // Most reads fall on or just around the latest painted square.
   task automatic send_random_request();
      int                w;
      int                h;
      int                pick;
      logic [KIND_W-1:0] k;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [CODE_W-1:0] code;
      w    = visible_width();
      h    = visible_height();
      pick = $urandom_range(0, 99);
      x    = POS_W'($urandom_range(0, SIDE - 1));
      y    = POS_W'($urandom_range(0, SIDE - 1));
      code = CODE_W'($urandom_range(0, 255));
      if (pick < 2) begin
         k = KIND_CLEAR;
      end else if (pick < 45) begin
         k = KIND_PAINT;
         if (w > 0 && h > 0 && $urandom_range(0, 3) != 0) begin
            x = POS_W'($urandom_range(0, w - 1));
            y = POS_W'($urandom_range(0, h - 1));
         end
         hot_x = x;
         hot_y = y;
         hot_r = int'(code) / 10 - 1;
         if (hot_r < 0)
            hot_r = 0;
      end else if (pick < 94) begin
         k = KIND_READ;
         if ($urandom_range(0, 9) < 7) begin
            x = POS_W'(hot_x + $urandom_range(0, 2 * hot_r + 4) - (hot_r + 2));
            y = POS_W'(hot_y + $urandom_range(0, 2 * hot_r + 4) - (hot_r + 2));
         end
      end else begin
         k = KIND_UNUSED;
      end
      send_request(k, x, y, code, 1'b0, LEVEL_OFF);
   endtask

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: level %0d", rsp_tdata);
         end else begin
            if (rsp_tdata !== pending_levels[0]) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("level mismatch: expected %0d, got %0d",
                           pending_levels[0], rsp_tdata);
            end
            void'(pending_levels.pop_front());
         end
      end
   end

   // The receiver switches between free flow, random ready, sparse ready and a periodic ready pattern.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_phase++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         2:       rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= ((stall_phase % 11) < 4);
      endcase
   end

   // Ends the run when nothing has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_distance_square_dilation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int w;
      int h;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = KIND_CLEAR;
      rsp_tready   = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = REG_FRAME_WIDTH;
      csr_data     = '0;
      mismatches   = 0;
      burst_left   = 0;
      quiet_cycles = 0;
      hot_x        = 0;
      hot_y        = 0;
      hot_r        = 0;
      stall_mode   = 0;
      stall_left   = 0;
      stall_phase  = 0;
      frame_w      = FRAME_RESET;
      frame_h      = FRAME_RESET;
      for (int r = 0; r < SIDE; r++)
         mark_rows[r] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].act == ROW_FRAME)
            program_frame(DIRECTED_PLAN[i].a, DIRECTED_PLAN[i].b);
         else
            send_request(DIRECTED_PLAN[i].kind, POS_W'(DIRECTED_PLAN[i].a),
                         POS_W'(DIRECTED_PLAN[i].b), DIRECTED_PLAN[i].code,
                         DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin w = 512;  h = 512;  end
            1:       begin w = 1023; h = 1023; end
            2:       begin w = 1;    h = 1;    end
            3:       begin w = $urandom_range(1, 512);   h = $urandom_range(1, 512); end
            4:       begin w = 512;  h = $urandom_range(1, 64); end
            default: begin w = $urandom_range(513, 1023); h = $urandom_range(1, 512); end
         endcase
         program_frame(COORD_W'(w), COORD_W'(h));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Now and then the sender waits for every response to come back.
            if ($urandom_range(0, 99) == 0)
               drain_responses();
            send_random_request();
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0)
         $display("tb_distance_square_dilation passed");
      else
         $display("tb_distance_square_dilation failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/dsd_pkg.sv
rtl/dsd_cmd_queue.sv
rtl/dsd_front.sv
rtl/dsd_back.sv
rtl/distance_square_dilation.sv
tb/tb_distance_square_dilation.sv
